// File: rtl/bitplane_pixel_fetch_macros.svh
// ---------------------------------------------------------------------------
// bitplane_pixel_fetch_macros.svh
// Assertion macros used by the bitplane pixel fetch RTL.
// ---------------------------------------------------------------------------
`ifndef BITPLANE_PIXEL_FETCH_MACROS_SVH
`define BITPLANE_PIXEL_FETCH_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted (active low).
`define BPF_ASSERT_IMPL(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted (active low).
`define BPF_ASSERT_NEXT(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/bpf_pkg.sv
// ---------------------------------------------------------------------------
// bpf_pkg
// Types and constants of the bitplane pixel fetch block.
// ---------------------------------------------------------------------------
package bpf_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  // Byte addresses of all layouts stay below 2**24; one bit of headroom.
  localparam int ADDR_W     = 25;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LINE_BYTES    = 3'd0,
    REG_IMAGE_HEIGHT  = 3'd1,
    REG_PLANE_COUNT   = 3'd2,
    REG_LAYOUT_MODE   = 3'd3,
    REG_PLANE_SKIP    = 3'd4,
    REG_OPTIONS       = 3'd5,
    REG_PLANE_ORDER   = 3'd6,
    REG_SOURCE_LENGTH = 3'd7
  } bpf_reg_t;

  localparam logic [2:0] LAYOUT_SEPARATE   = 3'd0;
  localparam logic [2:0] LAYOUT_INTERLEAVE = 3'd1;
  localparam logic [2:0] LAYOUT_SPRITE     = 3'd2;
  localparam logic [2:0] LAYOUT_PACKED     = 3'd3;
  localparam logic [2:0] LAYOUT_NIBBLE     = 3'd4;

  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_FETCH = 1'b1;

  localparam int OPT_REVERSE = 0;
  localparam int OPT_SKIP    = 1;

  localparam logic [9:0]  RST_LINE_BYTES    = 10'd40;
  localparam logic [9:0]  RST_IMAGE_HEIGHT  = 10'd200;
  localparam logic [3:0]  RST_PLANE_COUNT   = 4'd1;
  localparam logic [2:0]  RST_LAYOUT_MODE   = LAYOUT_SEPARATE;
  localparam logic [15:0] RST_PLANE_SKIP    = 16'd0;
  localparam logic [1:0]  RST_OPTIONS       = 2'd0;
  localparam logic [23:0] RST_PLANE_ORDER   = 24'hFAC688;
  localparam logic [16:0] RST_SOURCE_LENGTH = 17'd0;

  typedef struct packed {
    logic [9:0]  line_bytes;
    logic [9:0]  image_height;
    logic [3:0]  plane_count;
    logic [2:0]  layout_mode;
    logic [15:0] plane_skip;
    logic [1:0]  options;
    logic [23:0] plane_order;
    logic [16:0] source_length;
  } bpf_cfg_t;

endpackage

// File: rtl/bitplane_pixel_fetch.sv
// ---------------------------------------------------------------------------
// bitplane_pixel_fetch
// Byte image memory with a planar-to-chunky pixel fetch engine.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries write or fetch transactions.
//   A write (in_action = 0) stores in_write_byte at in_write_address in the
//   accept cycle; the engine stays idle, so the next transaction can be taken in the next cycle.
//   A fetch (in_action = 1) walks the P active planes (plane_count clamped
//   to MAX_PLANES) through the single memory port, at most one byte read per plane.
//   The colour is loaded into the output register in FINISH, after PREP1,
//   PREP2, ISSUE and DRAIN (the last two skipped for zero planes); a new
//   transaction is taken as the colour appears, so a fetch holds the input.
//   The result sits in an output register: a stalled receiver does not block
//   the next transaction, only the hand-off of the following fetch result.
//   Configuration writes (cfg_we) apply at once; the user must make them while idle, as the block does not enforce it.
//   Reset (rst_n low, synchronous) returns configuration to defaults and
//   empties the engine; image memory contents are not cleared.
// ---------------------------------------------------------------------------
`include "bitplane_pixel_fetch_macros.svh"

module bitplane_pixel_fetch import bpf_pkg::*; #(
  parameter int MEM_BYTES  = 65536,
  parameter int MAX_PLANES = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_action,
  input  logic [15:0]           in_write_address,
  input  logic [7:0]            in_write_byte,
  input  logic [15:0]           in_base,
  input  logic [12:0]           in_pixel_x,
  input  logic [9:0]            in_pixel_y,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            out_colour_index
);

  localparam int AW = $clog2(MEM_BYTES);
  localparam logic [ADDR_W-1:0] MEM_LIM    = ADDR_W'(MEM_BYTES);
  localparam logic [3:0]        PLANES_LIM = 4'(MAX_PLANES);

  typedef enum logic [2:0] {
    ST_IDLE, ST_PREP1, ST_PREP2, ST_ISSUE, ST_DRAIN, ST_FINISH
  } state_t;

  bpf_cfg_t cfg;

  bpf_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  state_t                state_r;
  logic                  out_valid_r;
  logic [7:0]            out_colour_r;
  logic [15:0]           base_r;
  logic [12:0]           x_r;
  logic [9:0]            y_r;
  logic [19:0]           yw_r;
  logic [19:0]           wh_r;
  logic [3:0]            planes_r;
  logic [ADDR_W-1:0]     addr_r;
  logic [ADDR_W-1:0]     stride_a_r;
  logic [ADDR_W-1:0]     stride_b_r;
  logic [2:0]            plane_r;
  logic                  rd_v_r;
  logic                  rd_ok_r;
  logic [2:0]            rd_pos_r;
  logic [2:0]            rd_slot_r;
  logic [MAX_PLANES-1:0] pbit_r;
  logic [7:0]            mem_q_r;

  logic [7:0] mem [MEM_BYTES];

  logic              in_acc;
  logic              mem_we;
  logic [ADDR_W-1:0] wr_addr;
  logic              rd_en;
  logic              mode_ok;
  logic              rd_ok;
  logic [2:0]        rd_pos;
  logic [2:0]        rd_slot;
  logic              last_plane;
  logic [ADDR_W-1:0] step;
  logic [ADDR_W-1:0] addr_nxt;
  logic [ADDR_W-1:0] start_nxt;
  logic [ADDR_W-1:0] stride_a_nxt;
  logic [ADDR_W-1:0] stride_b_nxt;
  logic [7:0]        colour_nxt;
  logic              out_free;

  assign in_ready         = (state_r == ST_IDLE);
  assign in_acc           = in_valid && in_ready;
  assign out_valid        = out_valid_r;
  assign out_colour_index = out_colour_r;
  assign out_free         = !out_valid_r || out_ready;

  assign wr_addr = ADDR_W'(in_write_address);
  assign mem_we  = in_acc && (in_action == ACT_WRITE) && (wr_addr < MEM_LIM);

  // Per-fetch start address and plane strides (skip folded in).
  always_comb begin
    logic [ADDR_W-1:0] yw;
    logic [ADDR_W-1:0] wh;
    logic [ADDR_W-1:0] w;
    logic [ADDR_W-1:0] xb;
    logic [ADDR_W-1:0] skip;
    logic [ADDR_W-1:0] row0;
    yw   = ADDR_W'(yw_r);
    wh   = ADDR_W'(wh_r);
    w    = ADDR_W'(cfg.line_bytes);
    xb   = ADDR_W'(x_r[12:3]);
    skip = cfg.options[OPT_SKIP] ? ADDR_W'(cfg.plane_skip) : '0;
    row0         = '0;
    stride_a_nxt = '0;
    stride_b_nxt = '0;
    case (cfg.layout_mode)
      LAYOUT_SEPARATE: begin
        row0         = yw + xb;
        stride_a_nxt = wh;
        stride_b_nxt = wh;
      end
      LAYOUT_INTERLEAVE: begin
        row0         = ADDR_W'(ADDR_W'(planes_r) * yw) + xb;
        stride_a_nxt = w;
        stride_b_nxt = w;
      end
      LAYOUT_SPRITE: begin
        // planes 2 and up start 2*W*H past the base; wraps cancel out
        row0         = (yw << 1) + xb;
        stride_a_nxt = w;
        stride_b_nxt = (wh << 1) - w;
      end
      LAYOUT_PACKED: begin
        row0         = (yw << 1) + (xb << 1);
        stride_a_nxt = ADDR_W'(1);
        stride_b_nxt = ADDR_W'(1);
      end
      LAYOUT_NIBBLE: begin
        row0         = (yw << 1) + ADDR_W'(x_r[12:2]);
        stride_a_nxt = '0;
        stride_b_nxt = ADDR_W'(1);
      end
      default: ;
    endcase
    start_nxt    = ADDR_W'(base_r) + row0;
    stride_a_nxt = stride_a_nxt + skip;
    stride_b_nxt = stride_b_nxt + skip;
  end

  // Read issue for the current plane.
  always_comb begin
    logic use_b;
    mode_ok = (cfg.layout_mode == LAYOUT_SEPARATE) || (cfg.layout_mode == LAYOUT_INTERLEAVE) ||
              (cfg.layout_mode == LAYOUT_SPRITE) || (cfg.layout_mode == LAYOUT_PACKED) ||
              (cfg.layout_mode == LAYOUT_NIBBLE);
    rd_ok   = mode_ok && (addr_r < ADDR_W'(cfg.source_length)) && (addr_r < MEM_LIM);
    rd_en   = (state_r == ST_ISSUE) && rd_ok;
    rd_pos  = (cfg.layout_mode == LAYOUT_NIBBLE) ? ~{plane_r[0], x_r[1:0]} : ~x_r[2:0];
    rd_slot = cfg.options[OPT_REVERSE] ? 3'(planes_r - 4'd1 - {1'b0, plane_r}) : plane_r;
    last_plane = ({1'b0, plane_r} == (planes_r - 4'd1));
    use_b   = ((cfg.layout_mode == LAYOUT_SPRITE) && (plane_r == 3'd1)) ||
              ((cfg.layout_mode == LAYOUT_NIBBLE) && plane_r[0]);
    step     = use_b ? stride_b_r : stride_a_r;
    addr_nxt = addr_r + step;
  end

  // Colour bit c takes the plane bit named by field c of plane_order; bits at or above the plane count stay zero.
  always_comb begin
    logic [2:0] sel;
    colour_nxt = '0;
    for (int c = 0; c < 8; c++) begin
      sel = cfg.plane_order[3*c +: 3];
      for (int k = 0; k < MAX_PLANES; k++) begin
        if ((sel == 3'(k)) && pbit_r[k] && (4'(c) < planes_r)) begin
          colour_nxt[c] = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr[AW-1:0]] <= in_write_byte;
    end
    if (rd_en) begin
      mem_q_r <= mem[addr_r[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      rd_v_r      <= 1'b0;
    end else begin
      rd_v_r <= (state_r == ST_ISSUE);
      if ((state_r == ST_FINISH) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (rd_v_r) begin
        for (int k = 0; k < MAX_PLANES; k++) begin
          if (rd_slot_r == 3'(k)) begin
            pbit_r[k] <= rd_ok_r && mem_q_r[rd_pos_r];
          end
        end
      end
      case (state_r)
        ST_IDLE: begin
          if (in_acc && (in_action == ACT_FETCH)) begin
            base_r  <= in_base;
            x_r     <= in_pixel_x;
            y_r     <= in_pixel_y;
            state_r <= ST_PREP1;
          end
        end
        ST_PREP1: begin
          yw_r     <= 20'(y_r) * 20'(cfg.line_bytes);
          wh_r     <= 20'(cfg.line_bytes) * 20'(cfg.image_height);
          planes_r <= (cfg.plane_count > PLANES_LIM) ? PLANES_LIM : cfg.plane_count;
          state_r  <= ST_PREP2;
        end
        ST_PREP2: begin
          addr_r     <= start_nxt;
          stride_a_r <= stride_a_nxt;
          stride_b_r <= stride_b_nxt;
          plane_r    <= '0;
          pbit_r     <= '0;
          state_r    <= (planes_r == 4'd0) ? ST_FINISH : ST_ISSUE;
        end
        ST_ISSUE: begin
          rd_ok_r   <= rd_ok;
          rd_pos_r  <= rd_pos;
          rd_slot_r <= rd_slot;
          addr_r    <= addr_nxt;
          plane_r   <= plane_r + 3'd1;
          if (last_plane) begin
            state_r <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          // last read data lands in pbit_r at this edge
          state_r <= ST_FINISH;
        end
        ST_FINISH: begin
          if (out_free) begin
            out_colour_r <= colour_nxt;
            state_r      <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  `BPF_ASSERT_IMPL(a_read_in_range, clk, rst_n, rd_en, addr_r < MEM_LIM, "memory read out of range")
  `BPF_ASSERT_IMPL(a_idle_no_read, clk, rst_n, in_ready, !rd_v_r && !rd_en, "read active while idle")
  `BPF_ASSERT_NEXT(a_fetch_start, clk, rst_n, in_acc && (in_action == ACT_FETCH), state_r == ST_PREP1, "fetch did not start")
  `BPF_ASSERT_IMPL(a_slot_range, clk, rst_n, rd_v_r, {1'b0, rd_slot_r} < PLANES_LIM, "plane slot out of range")
  `BPF_ASSERT_NEXT(a_finish_hold, clk, rst_n, (state_r == ST_FINISH) && out_valid_r && !out_ready, state_r == ST_FINISH, "result overwrote pending output")

endmodule

// File: rtl/bpf_cfg_regs.sv
// ---------------------------------------------------------------------------
// bpf_cfg_regs
// Configuration register file: decodes writes and holds reset values.
// ---------------------------------------------------------------------------
module bpf_cfg_regs import bpf_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output bpf_cfg_t              cfg
);

  bpf_cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.line_bytes    <= RST_LINE_BYTES;
      cfg_r.image_height  <= RST_IMAGE_HEIGHT;
      cfg_r.plane_count   <= RST_PLANE_COUNT;
      cfg_r.layout_mode   <= RST_LAYOUT_MODE;
      cfg_r.plane_skip    <= RST_PLANE_SKIP;
      cfg_r.options       <= RST_OPTIONS;
      cfg_r.plane_order   <= RST_PLANE_ORDER;
      cfg_r.source_length <= RST_SOURCE_LENGTH;
    end else if (cfg_we) begin
      case (bpf_reg_t'(cfg_index))
        REG_LINE_BYTES:    cfg_r.line_bytes    <= cfg_wdata[9:0];
        REG_IMAGE_HEIGHT:  cfg_r.image_height  <= cfg_wdata[9:0];
        REG_PLANE_COUNT:   cfg_r.plane_count   <= cfg_wdata[3:0];
        REG_LAYOUT_MODE:   cfg_r.layout_mode   <= cfg_wdata[2:0];
        REG_PLANE_SKIP:    cfg_r.plane_skip    <= cfg_wdata[15:0];
        REG_OPTIONS:       cfg_r.options       <= cfg_wdata[1:0];
        REG_PLANE_ORDER:   cfg_r.plane_order   <= cfg_wdata[23:0];
        REG_SOURCE_LENGTH: cfg_r.source_length <= cfg_wdata[16:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule
